// File: hw/rtl/dws_pkg.sv
`default_nettype none

package dws_pkg;

    // Height word width, Q3.12 at the default
    localparam int HEIGHT_BITS = 16;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Q0.16 coefficients
    localparam int COEFF_BITS = 16;
    localparam int ROUND_HALF = 1 << (COEFF_BITS - 1);

    // Configuration register map
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_COEFF = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_DAMPING    = CFG_INDEX_BITS'(1);

    localparam logic [COEFF_BITS-1:0] WAVE_COEFF_RESET = 16'd19661;
    localparam logic [COEFF_BITS-1:0] DAMPING_RESET    = 16'd65241;

    // Column window fill level
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_MANY = 2'd2;

    // Slots of the job data word, each one height wide
    localparam int FLD_LEFT   = 0;
    localparam int FLD_RIGHT  = 1;
    localparam int FLD_UP     = 2;
    localparam int FLD_DOWN   = 3;
    localparam int FLD_CENTER = 4;
    localparam int FLD_OLD    = 5;
    localparam int FLD_SECOND = 6;
    localparam int FLD_COUNT  = 7;

    // What a job asks of the back end
    typedef struct packed {
        logic first_valid;   // result for the pending center column
        logic first_calc;    // that result needs the stencil update
        logic second_valid;  // row end: pass this column through, row_done set
    } job_flags_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LAP,
        BK_MUL1,
        BK_MUL2,
        BK_RND,
        BK_FIRST,
        BK_SECOND
    } back_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/damped_wave_stencil_step.sv
// One step of a damped 2D wave equation, five-point stencil, streamed by column.
// Input queue side (push/full): one transfer per column carries the current
// heights of the rows above, at and below the center row, the previous-step
// height at the center cell, edge_row and row_end. Result queue side
// (empty/pop): one cell height per transfer, in column order, row_done on the
// last column of a row. Results lag one column; row_end flushes the pending
// cell and then passes the last column through.
// Config channel (cfg_valid/cfg_ready): index 0 wave_coeff, 1 damping, both
// Q0.16; write only while the block is idle. cfg_ready is always high.
// Sequencing: the back end takes no new job until the current one is loaded. An
// interior cell runs through queue read, laplacian, two multiply steps,
// rounding and result load; a pass-through cell goes from the queue read to
// the result load, and a row end also loads the last column with row_done set.
// Each result load waits until the result register is free (popped or empty).
// A two-entry job queue and the result register let input transfers go on
// while the receiver stalls; full rises once both queue entries are taken.
// Reset clears the column window, the queues and restores coefficient defaults.
`default_nettype none

module damped_wave_stencil_step #(
    parameter int HEIGHT_BITS = dws_pkg::HEIGHT_BITS,
    parameter int QUEUE_DEPTH = dws_pkg::QUEUE_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input queue side
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [HEIGHT_BITS-1:0]        up_height,
    input  wire logic signed [HEIGHT_BITS-1:0]        mid_height,
    input  wire logic signed [HEIGHT_BITS-1:0]        down_height,
    input  wire logic signed [HEIGHT_BITS-1:0]        old_height,
    input  wire logic                                 edge_row,
    input  wire logic                                 row_end,
    // result queue side
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [HEIGHT_BITS-1:0]             new_height,
    output logic                                      row_done,
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [dws_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [dws_pkg::COEFF_BITS-1:0]       cfg_data
);

    localparam int FLAG_W = $bits(dws_pkg::job_flags_t);
    localparam int DATA_W = dws_pkg::FLD_COUNT * HEIGHT_BITS;
    localparam int JOB_W  = FLAG_W + DATA_W;

    logic [dws_pkg::COEFF_BITS-1:0] wave_coeff_reg;
    logic [dws_pkg::COEFF_BITS-1:0] damping_reg;

    // front -> queue
    logic                q_full;
    logic                q_push;
    dws_pkg::job_flags_t push_flags;
    logic [DATA_W-1:0]   push_data;

    // queue -> back
    logic                q_empty;
    logic                q_pop;
    logic [JOB_W-1:0]    pop_job;
    dws_pkg::job_flags_t pop_flags;
    logic [DATA_W-1:0]   pop_data;

    // Coefficient registers; taken at any time, used as given
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_coeff_reg <= dws_pkg::WAVE_COEFF_RESET;
            damping_reg    <= dws_pkg::DAMPING_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dws_pkg::REG_WAVE_COEFF: wave_coeff_reg <= cfg_data;
                dws_pkg::REG_DAMPING:    damping_reg    <= cfg_data;
                default:
                begin
                    // unmapped index: dropped
                end
            endcase
        end
    end

    // Front: column window, turns each column that releases a cell into a job
    dws_front #(
        .HEIGHT_BITS(HEIGHT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .up_height  (up_height),
        .mid_height (mid_height),
        .down_height(down_height),
        .old_height (old_height),
        .edge_row   (edge_row),
        .row_end    (row_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_flags    (push_flags),
        .q_data     (push_data)
    );

    // Job queue decouples the window from the arithmetic
    dws_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_data({push_flags, push_data}),
        .q_full (q_full),
        .rd_en  (q_pop),
        .rd_data(pop_job),
        .q_empty(q_empty)
    );

    assign pop_flags = dws_pkg::job_flags_t'(pop_job[JOB_W-1:DATA_W]);
    assign pop_data  = pop_job[DATA_W-1:0];

    // Back: stencil arithmetic sequencer and result register
    dws_back #(
        .HEIGHT_BITS(HEIGHT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_flags   (pop_flags),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .wave_coeff(wave_coeff_reg),
        .damping   (damping_reg),
        .empty     (empty),
        .pop       (pop),
        .new_height(new_height),
        .row_done  (row_done)
    );

endmodule

`default_nettype wire

// File: hw/rtl/dws_queue.sv
`default_nettype none

module dws_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dws_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  q_full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dws_front.sv
`default_nettype none

module dws_front #(
    parameter int HEIGHT_BITS = dws_pkg::HEIGHT_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [HEIGHT_BITS-1:0] up_height,
    input  wire logic signed [HEIGHT_BITS-1:0] mid_height,
    input  wire logic signed [HEIGHT_BITS-1:0] down_height,
    input  wire logic signed [HEIGHT_BITS-1:0] old_height,
    input  wire logic                          edge_row,
    input  wire logic                          row_end,
    input  wire logic                          q_full,
    output logic                               q_push,
    output dws_pkg::job_flags_t                q_flags,
    output logic [dws_pkg::FLD_COUNT*HEIGHT_BITS-1:0] q_data
);

    localparam int H = HEIGHT_BITS;

    logic signed [H-1:0] mid_left_reg;
    logic signed [H-1:0] mid_center_reg;
    logic signed [H-1:0] up_center_reg;
    logic signed [H-1:0] down_center_reg;
    logic signed [H-1:0] old_center_reg;
    logic                edge_center_reg;
    logic [1:0]          columns_seen_reg;
    logic                accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        q_flags.first_valid  = (columns_seen_reg != dws_pkg::SEEN_NONE);
        q_flags.first_calc   = (columns_seen_reg == dws_pkg::SEEN_MANY) && !edge_center_reg;
        q_flags.second_valid = row_end;
    end

    // only items that give at least one result go on the queue
    assign q_push = accept && (q_flags.first_valid || q_flags.second_valid);

    always_comb
    begin
        q_data[dws_pkg::FLD_LEFT*H   +: H] = mid_left_reg;
        q_data[dws_pkg::FLD_RIGHT*H  +: H] = mid_height;
        q_data[dws_pkg::FLD_UP*H     +: H] = up_center_reg;
        q_data[dws_pkg::FLD_DOWN*H   +: H] = down_center_reg;
        q_data[dws_pkg::FLD_CENTER*H +: H] = mid_center_reg;
        q_data[dws_pkg::FLD_OLD*H    +: H] = old_center_reg;
        q_data[dws_pkg::FLD_SECOND*H +: H] = old_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_left_reg     <= '0;
            mid_center_reg   <= '0;
            up_center_reg    <= '0;
            down_center_reg  <= '0;
            old_center_reg   <= '0;
            edge_center_reg  <= 1'b0;
            columns_seen_reg <= dws_pkg::SEEN_NONE;
        end
        else if (accept)
        begin
            mid_left_reg    <= mid_center_reg;
            mid_center_reg  <= mid_height;
            up_center_reg   <= up_height;
            down_center_reg <= down_height;
            old_center_reg  <= old_height;
            edge_center_reg <= edge_row;
            if (row_end)
            begin
                columns_seen_reg <= dws_pkg::SEEN_NONE;
            end
            else if (columns_seen_reg == dws_pkg::SEEN_MANY)
            begin
                columns_seen_reg <= dws_pkg::SEEN_MANY;
            end
            else
            begin
                columns_seen_reg <= 2'(columns_seen_reg + 2'd1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dws_back.sv
`default_nettype none

module dws_back #(
    parameter int HEIGHT_BITS = dws_pkg::HEIGHT_BITS
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    q_empty,
    input  wire dws_pkg::job_flags_t                     q_flags,
    input  wire logic [dws_pkg::FLD_COUNT*HEIGHT_BITS-1:0] q_data,
    output logic                                         q_pop,
    input  wire logic [dws_pkg::COEFF_BITS-1:0]          wave_coeff,
    input  wire logic [dws_pkg::COEFF_BITS-1:0]          damping,
    output logic                                         empty,
    input  wire logic                                    pop,
    output logic signed [HEIGHT_BITS-1:0]                new_height,
    output logic                                         row_done
);

    localparam int H     = HEIGHT_BITS;
    localparam int CB    = dws_pkg::COEFF_BITS;
    localparam int LAP_W = H + 3;
    localparam int BAS_W = H + 2;
    localparam int P1_W  = LAP_W + CB + 1;
    localparam int R1_W  = P1_W - CB;
    localparam int IN_W  = R1_W + 1;
    localparam int P2_W  = IN_W + CB + 1;
    localparam int R2_W  = P2_W - CB;

    dws_pkg::back_state_t state_reg;
    dws_pkg::back_state_t state_next;
    dws_pkg::job_flags_t  flags_reg;

    logic [dws_pkg::FLD_COUNT*H-1:0] data_reg;
    logic signed [LAP_W-1:0] lap_reg;
    logic signed [BAS_W-1:0] base_reg;
    logic signed [P1_W-1:0]  p1_reg;
    logic signed [P2_W-1:0]  p2_reg;
    logic signed [H-1:0]     res_reg;
    logic                    out_valid_reg;
    logic signed [H-1:0]     out_height_reg;
    logic                    out_done_reg;

    logic signed [H-1:0]     f_left;
    logic signed [H-1:0]     f_right;
    logic signed [H-1:0]     f_up;
    logic signed [H-1:0]     f_down;
    logic signed [H-1:0]     f_center;
    logic signed [H-1:0]     f_old;
    logic signed [H-1:0]     f_second;
    logic signed [LAP_W-1:0] lap;
    logic signed [BAS_W-1:0] base;
    logic signed [P1_W-1:0]  p1;
    logic signed [P1_W-1:0]  t1;
    logic signed [R1_W-1:0]  r1;
    logic signed [IN_W-1:0]  inner;
    logic signed [P2_W-1:0]  p2;
    logic signed [P2_W-1:0]  t2;
    logic signed [R2_W-1:0]  r2;
    logic                    r2_fits;
    logic signed [H-1:0]     sat;
    logic                    out_free;
    logic                    load_first;
    logic                    load_second;

    assign f_left   = $signed(data_reg[dws_pkg::FLD_LEFT*H   +: H]);
    assign f_right  = $signed(data_reg[dws_pkg::FLD_RIGHT*H  +: H]);
    assign f_up     = $signed(data_reg[dws_pkg::FLD_UP*H     +: H]);
    assign f_down   = $signed(data_reg[dws_pkg::FLD_DOWN*H   +: H]);
    assign f_center = $signed(data_reg[dws_pkg::FLD_CENTER*H +: H]);
    assign f_old    = $signed(data_reg[dws_pkg::FLD_OLD*H    +: H]);
    assign f_second = $signed(data_reg[dws_pkg::FLD_SECOND*H +: H]);

    // laplacian and 2c - old, exact
    assign lap  = LAP_W'(f_left) + LAP_W'(f_right) + LAP_W'(f_up) + LAP_W'(f_down)
                - (LAP_W'(f_center) <<< 2);
    assign base = (BAS_W'(f_center) <<< 1) - BAS_W'(f_old);

    assign p1 = P1_W'(lap_reg) * P1_W'($signed({1'b0, wave_coeff}));

    // round to nearest, ties up: add half, floor
    assign t1    = p1_reg + P1_W'(dws_pkg::ROUND_HALF);
    assign r1    = $signed(t1[P1_W-1:CB]);
    assign inner = IN_W'(base_reg) + IN_W'(r1);
    assign p2    = P2_W'(inner) * P2_W'($signed({1'b0, damping}));

    assign t2      = p2_reg + P2_W'(dws_pkg::ROUND_HALF);
    assign r2      = $signed(t2[P2_W-1:CB]);
    assign r2_fits = (r2[R2_W-1:H-1] == '0) || (r2[R2_W-1:H-1] == '1);
    assign sat     = r2_fits ? r2[H-1:0]
                   : (r2[R2_W-1] ? {1'b1, {(H-1){1'b0}}} : {1'b0, {(H-1){1'b1}}});

    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dws_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (!q_flags.first_valid)
                    begin
                        state_next = dws_pkg::BK_SECOND;
                    end
                    else if (q_flags.first_calc)
                    begin
                        state_next = dws_pkg::BK_LAP;
                    end
                    else
                    begin
                        state_next = dws_pkg::BK_FIRST;
                    end
                end
            end
            dws_pkg::BK_LAP:  state_next = dws_pkg::BK_MUL1;
            dws_pkg::BK_MUL1: state_next = dws_pkg::BK_MUL2;
            dws_pkg::BK_MUL2: state_next = dws_pkg::BK_RND;
            dws_pkg::BK_RND:  state_next = dws_pkg::BK_FIRST;
            dws_pkg::BK_FIRST:
            begin
                if (out_free)
                begin
                    state_next = flags_reg.second_valid ? dws_pkg::BK_SECOND : dws_pkg::BK_IDLE;
                end
            end
            dws_pkg::BK_SECOND:
            begin
                if (out_free)
                begin
                    state_next = dws_pkg::BK_IDLE;
                end
            end
            default: state_next = dws_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop       = 1'b0;
        load_first  = 1'b0;
        load_second = 1'b0;
        unique case (state_reg)
            dws_pkg::BK_IDLE:   q_pop       = !q_empty;
            dws_pkg::BK_FIRST:  load_first  = out_free;
            dws_pkg::BK_SECOND: load_second = out_free;
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dws_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_first || load_second)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        lap_reg  <= lap;
        base_reg <= base;
        p1_reg   <= p1;
        p2_reg   <= p2;
        if (q_pop)
        begin
            flags_reg <= q_flags;
            data_reg  <= q_data;
            res_reg   <= $signed(q_data[dws_pkg::FLD_OLD*H +: H]);
        end
        else if (state_reg == dws_pkg::BK_RND)
        begin
            res_reg <= sat;
        end
        if (load_first)
        begin
            out_height_reg <= res_reg;
            out_done_reg   <= 1'b0;
        end
        else if (load_second)
        begin
            out_height_reg <= f_second;
            out_done_reg   <= 1'b1;
        end
    end

    assign empty      = !out_valid_reg;
    assign new_height = out_height_reg;
    assign row_done   = out_done_reg;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
module tb_top;

    // Run control
    localparam int     DRAIN_CYCLES  = 32;       // back end takes one cell at a time, 2 jobs queued
    localparam int     LIMIT_TIME    = 3000000;  // several times the slowest run
    localparam int     MAX_REPORTS   = 10;
    localparam int     PHASE_COLUMNS = 175;      // six phases, ~1050 random columns
    localparam int     GAP_MAX       = 18;

    // Index outside the register map; a write there must change nothing
    localparam logic [dws_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED =
        dws_pkg::CFG_INDEX_BITS'(3);

    localparam longint HEIGHT_MAX = (longint'(1) << (dws_pkg::HEIGHT_BITS - 1)) - 1;
    localparam longint HEIGHT_MIN = -HEIGHT_MAX - 1;

    typedef logic signed [dws_pkg::HEIGHT_BITS-1:0] height_t;

    // One column as it crosses the input side
    typedef struct packed {
        height_t up;
        height_t mid;
        height_t down;
        height_t old;
        logic    edge_row;
        logic    row_end;
    } column_t;

    // One updated cell as it leaves the result side
    typedef struct packed {
        height_t h;
        logic    done;
    } cell_t;

    // DUT ports
    logic                               clk         = 1'b0;
    logic                               rst_n       = 1'b0;
    logic                               push        = 1'b0;
    logic                               full;
    height_t                            up_height   = '0;
    height_t                            mid_height  = '0;
    height_t                            down_height = '0;
    height_t                            old_height  = '0;
    logic                               edge_row    = 1'b0;
    logic                               row_end     = 1'b0;
    logic                               empty;
    logic                               pop         = 1'b0;
    height_t                            new_height;
    logic                               row_done;
    logic                               cfg_valid   = 1'b0;
    logic                               cfg_ready;
    logic [dws_pkg::CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [dws_pkg::COEFF_BITS-1:0]     cfg_data    = '0;

    // Stimulus and expected cells
    column_t columns_to_send[$];
    cell_t   due_cells[$];
    cell_t   head_cell;
    column_t seen_col;

    // Shadow of the column window and the coefficients
    height_t                        win_left   = '0;
    height_t                        win_center = '0;
    height_t                        win_up     = '0;
    height_t                        win_down   = '0;
    height_t                        win_old    = '0;
    logic                           win_edge   = 1'b0;
    logic [1:0]                     win_fill   = dws_pkg::SEEN_NONE;
    logic [dws_pkg::COEFF_BITS-1:0] coef_wave  = dws_pkg::WAVE_COEFF_RESET;
    logic [dws_pkg::COEFF_BITS-1:0] coef_damp  = dws_pkg::DAMPING_RESET;

    // Handshake bookkeeping between monitor (posedge) and driver (negedge)
    logic col_taken     = 1'b0;
    bit   calm          = 1'b0;   // no idling on either side once set
    int   send_gap      = 0;
    int   take_gap      = 0;
    int   send_idle_pct = 0;
    int   take_idle_pct = 0;
    int   fault_count   = 0;

    damped_wave_stencil_step u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .up_height   (up_height),
        .mid_height  (mid_height),
        .down_height (down_height),
        .old_height  (old_height),
        .edge_row    (edge_row),
        .row_end     (row_end),
        .empty       (empty),
        .pop         (pop),
        .new_height  (new_height),
        .row_done    (row_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Divide by 2^16, round to nearest, ties toward +inf.
    // Arithmetic shift of a signed value is a floor, so this is floor((x + half) / 2^16).
    function automatic longint round_q16(input longint x);
        return (x + longint'(dws_pkg::ROUND_HALF)) >>> dws_pkg::COEFF_BITS;
    endfunction

    // Height mix: mostly mid-range ripples, some full-scale noise, some rails, some 0 or -1
    function automatic height_t pick_height();
        int v;
        case ($urandom_range(0, 9))
            0:       v = ($urandom_range(0, 1) != 0) ? int'(HEIGHT_MAX) : int'(HEIGHT_MIN);
            1:       v = ($urandom_range(0, 1) != 0) ? 0 : -1;
            2, 3, 4: v = int'($urandom);
            default: v = int'($urandom_range(0, 8191)) - 4096;
        endcase
        return height_t'(v);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 4;
            2:       return 15;
            default: return 40;
        endcase
    endfunction

    // Advance the column window by one accepted column and queue the cells it releases.
    // The pending center is emitted first (pass-through on the first column or an
    // edge row), then a row end passes this column through with row_done set.
    task automatic step_window(input column_t c);
        longint lap;
        longint inner;
        longint upd;
        cell_t  out_cell;
        if (win_fill != dws_pkg::SEEN_NONE)
        begin
            if (win_fill == dws_pkg::SEEN_ONE || win_edge)
                upd = longint'(win_old);
            else
            begin
                lap   = longint'(win_left) + longint'(c.mid) + longint'(win_up)
                      + longint'(win_down) - 4 * longint'(win_center);
                inner = 2 * longint'(win_center) - longint'(win_old)
                      + round_q16(longint'(coef_wave) * lap);
                upd   = round_q16(inner * longint'(coef_damp));
                if (upd > HEIGHT_MAX)
                    upd = HEIGHT_MAX;
                else if (upd < HEIGHT_MIN)
                    upd = HEIGHT_MIN;
            end
            out_cell.h    = height_t'(upd);
            out_cell.done = 1'b0;
            due_cells.push_back(out_cell);
        end

        win_left   = win_center;
        win_center = c.mid;
        win_up     = c.up;
        win_down   = c.down;
        win_old    = c.old;
        win_edge   = c.edge_row;
        win_fill   = (win_fill == dws_pkg::SEEN_NONE) ? dws_pkg::SEEN_ONE : dws_pkg::SEEN_MANY;

        if (c.row_end)
        begin
            out_cell.h    = c.old;
            out_cell.done = 1'b1;
            due_cells.push_back(out_cell);
            win_fill      = dws_pkg::SEEN_NONE;
        end
    endtask

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%t: %s", $realtime, msg);
    endtask

    // Monitor: result check first, then prediction, so a column accepted on the
    // same edge can never satisfy a result popped on that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (due_cells.size() == 0)
                    log_fault($sformatf("unexpected cell: height %0d done %0b",
                                        new_height, row_done));
                else
                begin
                    head_cell = due_cells.pop_front();
                    if (new_height !== head_cell.h || row_done !== head_cell.done)
                        log_fault($sformatf(
                            "cell mismatch: expected height %0d done %0b, got height %0d done %0b",
                            head_cell.h, head_cell.done, new_height, row_done));
                end
            end
            if (push && !full)
            begin
                seen_col.up       = up_height;
                seen_col.mid      = mid_height;
                seen_col.down     = down_height;
                seen_col.old      = old_height;
                seen_col.edge_row = edge_row;
                seen_col.row_end  = row_end;
                step_window(seen_col);
                col_taken = 1'b1;
            end
        end
    end

    // Driver: inputs move on the falling edge. A column stays on the ports until
    // its transfer; idle bursts fall only between columns. The pop side stalls
    // in bursts of its own, independent of whether anything is waiting.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            pop  <= 1'b0;
        end
        else
        begin
            if (!push || col_taken)
            begin
                col_taken = 1'b0;
                if (!calm && $urandom_range(0, 39) == 0)
                    send_idle_pct = pick_idle_pct();
                if (send_gap > 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (columns_to_send.size() == 0)
                    push <= 1'b0;
                else if (!calm && int'($urandom_range(0, 99)) < send_idle_pct)
                begin
                    send_gap = int'($urandom_range(1, GAP_MAX)) - 1;
                    push <= 1'b0;
                end
                else
                begin
                    seen_col = columns_to_send.pop_front();
                    push        <= 1'b1;
                    up_height   <= seen_col.up;
                    mid_height  <= seen_col.mid;
                    down_height <= seen_col.down;
                    old_height  <= seen_col.old;
                    edge_row    <= seen_col.edge_row;
                    row_end     <= seen_col.row_end;
                end
            end

            if (!calm && $urandom_range(0, 39) == 0)
                take_idle_pct = pick_idle_pct();
            if (take_gap > 0)
            begin
                take_gap--;
                pop <= 1'b0;
            end
            else if (!calm && int'($urandom_range(0, 99)) < take_idle_pct)
            begin
                take_gap = int'($urandom_range(1, GAP_MAX)) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic add_column(input int up, input int mid, input int down, input int old,
                              input bit edge_flag, input bit last_flag);
        column_t c;
        c.up       = height_t'(up);
        c.mid      = height_t'(mid);
        c.down     = height_t'(down);
        c.old      = height_t'(old);
        c.edge_row = edge_flag;
        c.row_end  = last_flag;
        columns_to_send.push_back(c);
    endtask

    // Whole rows only, so every phase leaves the window empty.
    // Lengths lean short (one- and two-column rows are corner cases), a few long.
    task automatic queue_rows(input int count);
        int      queued;
        int      len;
        bit      row_is_edge;
        column_t c;
        queued = 0;
        while (queued < count)
        begin
            case ($urandom_range(0, 9))
                0:       len = 1;
                1:       len = 2;
                2:       len = int'($urandom_range(25, 40));
                default: len = int'($urandom_range(3, 24));
            endcase
            row_is_edge = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < len; i++)
            begin
                c.up       = pick_height();
                c.mid      = pick_height();
                c.down     = pick_height();
                c.old      = pick_height();
                // edge flag is per column at the port; flip it now and then
                c.edge_row = ($urandom_range(0, 29) == 0) ? !row_is_edge : row_is_edge;
                c.row_end  = (i == len - 1);
                columns_to_send.push_back(c);
            end
            queued += len;
        end
    endtask

    // Config writes go through the channel handshake; the shadow copy follows on transfer.
    task automatic write_reg(input logic [dws_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [dws_pkg::COEFF_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            dws_pkg::REG_WAVE_COEFF: coef_wave = value;
            dws_pkg::REG_DAMPING:    coef_damp = value;
            default:                 ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Idle means: every column transferred, every cell popped, then a pause of
    // DRAIN_CYCLES before the next phase.
    task automatic wait_idle();
        while (columns_to_send.size() != 0 || push)
            @(posedge clk);
        while (due_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = pick_idle_pct();
        take_idle_pct = pick_idle_pct();

        // Directed, reset coefficients.
        // First row: first column alone gives nothing, next releases it unchanged,
        // then interior cells driven to both rails and a large positive Laplacian,
        // an edge column mid-row, and the row end flush.
        add_column(0, 0, 0, 0, 0, 0);
        add_column(100, 200, 300, 50, 0, 0);
        add_column(32767, 32767, 32767, -32768, 0, 0);
        add_column(32767, 32767, 32767, 0, 0, 0);
        add_column(-32768, -32768, -32768, 32767, 0, 0);
        add_column(-32768, -32768, -32768, 32767, 0, 0);
        add_column(32767, -32768, 32767, 32767, 0, 0);
        add_column(32767, 32767, 32767, -1, 1, 0);
        add_column(1, -1, 1, -1, 0, 0);
        add_column(-1, 0, -1, 12345, 0, 1);
        // one-column row: a single pass-through with row_done
        add_column(123, -456, 789, -32768, 0, 1);
        // two-column row: both cells pass through
        add_column(10, 20, 30, 40, 0, 0);
        add_column(-10, -20, -30, -40, 0, 1);
        // edge row: nothing updated
        add_column(5, 6, 7, 8, 1, 0);
        add_column(1, 2, 3, 4, 1, 0);
        add_column(9, 9, 9, 9, 1, 0);
        add_column(0, 0, 0, 32767, 1, 1);
        // short ordinary row with typical ripple values
        add_column(4096, 2048, -4096, 1024, 0, 0);
        add_column(0, 4096, 0, -2048, 0, 0);
        add_column(-4096, 0, 4096, 0, 0, 1);
        wait_idle();

        // Random phases, one coefficient setting each
        queue_rows(PHASE_COLUMNS);
        wait_idle();

        write_reg(dws_pkg::REG_WAVE_COEFF, 16'd0);
        write_reg(dws_pkg::REG_DAMPING, 16'd65535);
        queue_rows(PHASE_COLUMNS);
        wait_idle();

        write_reg(dws_pkg::REG_WAVE_COEFF, 16'd32768);
        write_reg(dws_pkg::REG_DAMPING, 16'd0);
        queue_rows(PHASE_COLUMNS);
        wait_idle();

        // gain beyond its nominal range is taken as is; stray index is ignored
        write_reg(dws_pkg::REG_WAVE_COEFF, 16'd65535);
        write_reg(dws_pkg::REG_DAMPING, 16'd65535);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        queue_rows(PHASE_COLUMNS);
        wait_idle();

        write_reg(dws_pkg::REG_WAVE_COEFF, dws_pkg::COEFF_BITS'($urandom_range(0, 32768)));
        write_reg(dws_pkg::REG_DAMPING, dws_pkg::COEFF_BITS'($urandom));
        queue_rows(PHASE_COLUMNS);
        wait_idle();

        // last stretch at full rate, back on the reset values
        calm = 1'b1;
        write_reg(dws_pkg::REG_WAVE_COEFF, dws_pkg::WAVE_COEFF_RESET);
        write_reg(dws_pkg::REG_DAMPING, dws_pkg::DAMPING_RESET);
        queue_rows(PHASE_COLUMNS);
        wait_idle();

        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #LIMIT_TIME;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dws_pkg.sv
hw/rtl/dws_queue.sv
hw/rtl/dws_front.sv
hw/rtl/dws_back.sv
hw/rtl/damped_wave_stencil_step.sv
sim/tb_top.sv
